// ----- rtl/tcp_option_parser_core_assert.svh -----
// assertion macros for the tcp option parser
`ifndef TCP_OPTION_PARSER_CORE_ASSERT_SVH
`define TCP_OPTION_PARSER_CORE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define TCPOP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define TCPOP_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/tcpop_pkg.sv -----
// shared types, option codes and helpers of the tcp option parser
package tcpop_pkg;

    localparam logic [7:0] KIND_END    = 8'd0;
    localparam logic [7:0] KIND_NOOP   = 8'd1;
    localparam logic [7:0] KIND_MSS    = 8'd2;
    localparam logic [7:0] KIND_WS     = 8'd3;
    localparam logic [7:0] KIND_SACKOK = 8'd4;
    localparam logic [7:0] KIND_TS     = 8'd8;

    localparam logic [15:0] DEFAULT_MSS_RESET = 16'd1460;

    localparam int OUT_DATA_W = 64;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_WS   = 3'd1,
        OP_SACK = 3'd2,
        OP_MSS  = 3'd3,
        OP_TS   = 3'd4
    } op_t;

    // one command from the parser to the state update
    typedef struct packed {
        logic        conn_start;
        logic        last;
        logic        malformed;
        op_t         op;
        logic [31:0] value;
    } cmd_t;

    function automatic logic [7:0] expected_len(input logic [7:0] kind);
        logic [7:0] len;
        unique case (kind)
            KIND_MSS:    len = 8'd4;
            KIND_WS:     len = 8'd3;
            KIND_SACKOK: len = 8'd2;
            KIND_TS:     len = 8'd10;
            default:     len = 8'd0;
        endcase
        return len;
    endfunction

    function automatic op_t kind_to_op(input logic [7:0] kind);
        op_t op;
        unique case (kind)
            KIND_MSS:    op = OP_MSS;
            KIND_WS:     op = OP_WS;
            KIND_SACKOK: op = OP_SACK;
            KIND_TS:     op = OP_TS;
            default:     op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

// ----- rtl/tcp_option_parser_core.sv -----
// tcp option parser: one option byte per beat, one result beat per header
// the last byte's command passes through the command queue; the result register is loaded when it is popped
// throughput: one byte per cycle while the command queue is not full; the command queue absorbs output stalls
// the command queue's fill sets the byte rate, the result register the result rate
// rst_n is asynchronous, active low: parse and connection state cleared, default mss 1460
module tcp_option_parser_core
    import tcpop_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // option_byte
    input  logic                  s_tlast,  // last_byte
    input  logic                  s_tuser,  // conn_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // peer_wscale, sack_permitted, mss_seen, effective_mss, ts_seen, ts_recent, malformed
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic in_fire;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t head_cmd;
    logic empty;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    tcpop_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .option_byte (s_tdata),
        .last_byte   (s_tlast),
        .conn_start  (s_tuser),
        .push        (push),
        .cmd         (push_cmd)
    );

    tcpop_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    tcpop_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .empty       (empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ----- rtl/tcpop_fifo.sv -----
// command queue between the option parser and the state update
module tcpop_fifo
    import tcpop_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`include "tcp_option_parser_core_assert.svh"

    `TCPOP_NEVER(a_fifo_overflow, push && full && !pop, "push into full queue")
    `TCPOP_NEVER(a_fifo_underflow, pop && empty, "pop from empty queue")
    `TCPOP_ASSERT(a_fifo_count, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// ----- rtl/tcpop_front.sv -----
// option byte parser: walks the option area and emits update commands
module tcpop_front
    import tcpop_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] option_byte,
    input  logic       last_byte,
    input  logic       conn_start,
    output logic       push,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        PH_KIND  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_DRAIN = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] accum_reg, accum_next;
    logic        len_ok_reg, len_ok_next;
    logic        bad_reg, bad_next;
    logic        apply;
    logic        apply_ok;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        left_next   = left_reg;
        accum_next  = accum_reg;
        len_ok_next = len_ok_reg;
        bad_next    = bad_reg;
        apply       = 1'b0;

        unique case (phase_reg)
            PH_KIND:
            begin
                if (option_byte != KIND_END && option_byte != KIND_NOOP)
                begin
                    kind_next  = option_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (option_byte < 8'd2)
                begin
                    bad_next   = 1'b1;
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    len_ok_next = (option_byte == expected_len(kind_reg));
                    left_next   = option_byte - 8'd2;
                    accum_next  = '0;
                    if (option_byte == 8'd2)
                    begin
                        apply      = 1'b1;
                        phase_next = PH_KIND;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                // only the tsval part of a timestamp is kept
                if (kind_reg != KIND_TS || left_reg > 8'd4)
                begin
                    accum_next = {accum_reg[23:0], option_byte};
                end
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    apply      = 1'b1;
                    phase_next = PH_KIND;
                end
            end
            PH_DRAIN:
            begin
            end
            default:
            begin
                phase_next = PH_KIND;
            end
        endcase

        apply_ok = apply && len_ok_next;

        cmd.conn_start = conn_start;
        cmd.last       = last_byte;
        cmd.malformed  = bad_next || phase_next == PH_LEN || phase_next == PH_DATA;
        cmd.op         = apply_ok ? kind_to_op(kind_reg) : OP_NONE;
        cmd.value      = accum_next;

        push = in_fire && (conn_start || last_byte || apply_ok);

        // header end resets the parse but not the connection state
        if (last_byte)
        begin
            phase_next  = PH_KIND;
            kind_next   = '0;
            left_next   = '0;
            accum_next  = '0;
            len_ok_next = 1'b0;
            bad_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KIND;
            kind_reg   <= '0;
            left_reg   <= '0;
            accum_reg  <= '0;
            len_ok_reg <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            left_reg   <= left_next;
            accum_reg  <= accum_next;
            len_ok_reg <= len_ok_next;
            bad_reg    <= bad_next;
        end
    end

`include "tcp_option_parser_core_assert.svh"

    `TCPOP_ASSERT(a_data_has_bytes, phase_reg == PH_DATA |-> left_reg != 8'd0, "data phase with no bytes left")
    `TCPOP_ASSERT(a_drain_is_bad, phase_reg == PH_DRAIN |-> bad_reg, "drain without malformed mark")

endmodule

// ----- rtl/tcpop_back.sv -----
// connection state update and result register
module tcpop_back
    import tcpop_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  empty,
    input  cmd_t                  head_cmd,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [15:0] dflt_mss_reg;
    logic [7:0]  wscale_reg, wscale_next;
    logic        sack_reg, sack_next;
    logic        mss_flag_reg, mss_flag_next;
    logic [15:0] mss_reg, mss_next;
    logic        ts_flag_reg, ts_flag_next;
    logic [31:0] ts_reg, ts_next;
    logic        valid_reg, valid_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic        out_free;

    assign out_free = !valid_reg || m_tready;
    assign pop      = !empty && (!head_cmd.last || out_free);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb
    begin
        wscale_next   = wscale_reg;
        sack_next     = sack_reg;
        mss_flag_next = mss_flag_reg;
        mss_next      = mss_reg;
        ts_flag_next  = ts_flag_reg;
        ts_next       = ts_reg;

        if (head_cmd.conn_start)
        begin
            wscale_next   = '0;
            sack_next     = 1'b0;
            mss_flag_next = 1'b0;
            mss_next      = dflt_mss_reg;
            ts_flag_next  = 1'b0;
            ts_next       = '0;
        end

        unique case (head_cmd.op)
            OP_WS:   wscale_next = head_cmd.value[7:0];
            OP_SACK: sack_next = 1'b1;
            OP_MSS:
            begin
                mss_flag_next = 1'b1;
                if (mss_next > head_cmd.value[15:0])
                begin
                    mss_next = head_cmd.value[15:0];
                end
            end
            OP_TS:
            begin
                ts_flag_next = 1'b1;
                ts_next      = head_cmd.value;
            end
            default:
            begin
            end
        endcase

        data_next = {4'd0, head_cmd.malformed, ts_next, ts_flag_next, mss_next,
                     mss_flag_next, sack_next, wscale_next};

        valid_next = valid_reg;
        if (pop && head_cmd.last)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_mss_reg <= DEFAULT_MSS_RESET;
            wscale_reg   <= '0;
            sack_reg     <= 1'b0;
            mss_flag_reg <= 1'b0;
            mss_reg      <= DEFAULT_MSS_RESET;
            ts_flag_reg  <= 1'b0;
            ts_reg       <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dflt_mss_reg <= cfg_wr_data;
            end
            if (pop)
            begin
                wscale_reg   <= wscale_next;
                sack_reg     <= sack_next;
                mss_flag_reg <= mss_flag_next;
                mss_reg      <= mss_next;
                ts_flag_reg  <= ts_flag_next;
                ts_reg       <= ts_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.last)
        begin
            data_reg <= data_next;
        end
    end

`include "tcp_option_parser_core_assert.svh"

    `TCPOP_NEVER(a_result_overrun, pop && head_cmd.last && valid_reg && !m_tready, "result overwritten while stalled")
    `TCPOP_ASSERT(a_mss_flag_after_mss, pop && head_cmd.op == OP_MSS |=> mss_flag_reg, "mss flag not set")

endmodule
